// ----- hdl/xor_float_stream_encoder_top_defines.svh -----
// assertion macros for the xor float stream encoder, used by the back end
`ifndef XOR_FLOAT_STREAM_ENCODER_TOP_DEFINES_SVH
`define XOR_FLOAT_STREAM_ENCODER_TOP_DEFINES_SVH

`ifndef SYNTH

`define XFSE_ASSERT(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("xfse assertion failed");

`define XFSE_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("xfse assertion failed");

`else

`define XFSE_ASSERT(label, clk, rst_n, cond)

`define XFSE_ASSERT_NEXT(label, clk, rst_n, trig, cond)

`endif

`endif

// ----- hdl/xfse_pkg.sv -----
// shared constants of the xor float stream encoder
package xfse_pkg;

    localparam int WORD_W       = 64;
    localparam int LZ_W         = 6;
    localparam int NARROW_BITS  = 32;
    localparam int NARROW_FIELD = 5;
    localparam int WIDE_FIELD   = 6;
    localparam int BYTE_W       = 8;
    localparam int PEND_W       = BYTE_W - 1;

endpackage

// ----- hdl/xfse_front.sv -----
// front end: accepts values, xors with the previous value and builds the bit record
module xfse_front #(
    parameter int VALUE_BITS = 64,
    parameter int ITEM_W     = 77,
    parameter int LEN_W      = 7
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wide_values,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [xfse_pkg::WORD_W-1:0] value_bits,
    input  logic                        chunk_end,
    output logic                        q_valid,
    input  logic                        q_ready,
    output logic [ITEM_W-1:0]           q_vec,
    output logic [LEN_W-1:0]            q_len,
    output logic                        q_last
);
    import xfse_pkg::*;

    typedef enum logic [1:0] {
        KIND_FIRST,
        KIND_ZERO,
        KIND_DELTA
    } kind_t;

    localparam logic [WORD_W-1:0] VALUE_MASK = (VALUE_BITS >= WORD_W) ? {WORD_W{1'b1}} :
        ((WORD_W'(1) << VALUE_BITS) - WORD_W'(1));
    localparam logic [WORD_W-1:0] NARROW_MASK = (WORD_W'(1) << NARROW_BITS) - WORD_W'(1);
    localparam int WIDE_JUST   = WORD_W - VALUE_BITS;
    localparam int NARROW_JUST = WORD_W - NARROW_BITS;
    localparam int TOT_W       = LZ_W + 1;

    function automatic logic [LZ_W-1:0] lead_zeros(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] s;
        logic [LZ_W-1:0]   n;
        s = w;
        n = '0;
        for (int i = LZ_W - 1; i >= 0; i--)
        begin
            if ((s >> (WORD_W - (1 << i))) == '0)
            begin
                n[i] = 1'b1;
                s    = s << (1 << i);
            end
        end
        return n;
    endfunction

    function automatic logic [WORD_W-1:0] bit_reverse(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] r;
        for (int i = 0; i < WORD_W; i++)
        begin
            r[i] = w[WORD_W-1-i];
        end
        return r;
    endfunction

    logic [WORD_W-1:0] prev_reg;
    logic              first_reg;
    logic              first_next;
    logic              s1_valid_reg;
    logic              s1_valid_next;
    kind_t             s1_kind_reg;
    logic [WORD_W-1:0] s1_word_reg;
    logic [LZ_W-1:0]   s1_lz_reg;
    logic [LZ_W-1:0]   s1_tz_reg;
    logic              s1_wide_reg;
    logic              s1_last_reg;

    logic              accept;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] masked_value;
    logic [WORD_W-1:0] delta;
    logic [WORD_W-1:0] justified;
    kind_t             kind;

    logic [TOT_W-1:0]  total;
    logic [TOT_W-1:0]  mlen;
    logic [TOT_W-1:0]  mlen_m1;
    logic [WORD_W-1:0] payload;

    assign in_ready = !s1_valid_reg || q_ready;
    assign accept   = in_valid && in_ready;

    assign mask         = wide_values ? VALUE_MASK : NARROW_MASK;
    assign masked_value = value_bits & mask;
    assign delta        = masked_value ^ (prev_reg & mask);
    assign justified    = wide_values ? (delta << WIDE_JUST) : (delta << NARROW_JUST);

    always_comb
    begin
        if (first_reg)
        begin
            kind = KIND_FIRST;
        end
        else if (delta == '0)
        begin
            kind = KIND_ZERO;
        end
        else
        begin
            kind = KIND_DELTA;
        end
    end

    always_comb
    begin
        first_next    = first_reg;
        s1_valid_next = s1_valid_reg;
        if (q_ready)
        begin
            s1_valid_next = 1'b0;
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
            first_next    = chunk_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg     <= '0;
            first_reg    <= 1'b1;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            first_reg    <= first_next;
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                prev_reg <= masked_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg <= kind;
            s1_word_reg <= first_reg ? masked_value : delta;
            s1_lz_reg   <= lead_zeros(justified);
            s1_tz_reg   <= lead_zeros(bit_reverse(delta));
            s1_wide_reg <= wide_values;
            s1_last_reg <= chunk_end;
        end
    end

    // record assembly: control bit, leading zeros, length minus one, meaningful bits
    assign total   = s1_wide_reg ? TOT_W'(VALUE_BITS) : TOT_W'(NARROW_BITS);
    assign mlen    = total - TOT_W'(s1_lz_reg) - TOT_W'(s1_tz_reg);
    assign mlen_m1 = mlen - TOT_W'(1);
    assign payload = s1_word_reg >> s1_tz_reg;

    always_comb
    begin
        q_vec = '0;
        q_len = '0;
        unique case (s1_kind_reg)
            KIND_FIRST:
            begin
                q_vec = ITEM_W'(s1_word_reg);
                q_len = LEN_W'(total);
            end
            KIND_ZERO:
            begin
                q_vec = '0;
                q_len = LEN_W'(1);
            end
            KIND_DELTA:
            begin
                if (s1_wide_reg)
                begin
                    q_vec = (ITEM_W'(payload) << (1 + 2 * WIDE_FIELD))
                          | (ITEM_W'(mlen_m1[WIDE_FIELD-1:0]) << (1 + WIDE_FIELD))
                          | (ITEM_W'(s1_lz_reg[WIDE_FIELD-1:0]) << 1)
                          | ITEM_W'(1);
                    q_len = LEN_W'(1 + 2 * WIDE_FIELD) + LEN_W'(mlen);
                end
                else
                begin
                    q_vec = (ITEM_W'(payload) << (1 + 2 * NARROW_FIELD))
                          | (ITEM_W'(mlen_m1[NARROW_FIELD-1:0]) << (1 + NARROW_FIELD))
                          | (ITEM_W'(s1_lz_reg[NARROW_FIELD-1:0]) << 1)
                          | ITEM_W'(1);
                    q_len = LEN_W'(1 + 2 * NARROW_FIELD) + LEN_W'(mlen);
                end
            end
            default:
            begin
                q_vec = '0;
                q_len = '0;
            end
        endcase
    end

    assign q_valid = s1_valid_reg;
    assign q_last  = s1_last_reg;

endmodule

// ----- hdl/xfse_queue.sv -----
// small fifo of bit records between the front end and the packer
module xfse_queue #(
    parameter int WIDTH = 85,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hdl/xfse_back.sv -----
// back end: merges bit records into the pending bits and sends out bytes
module xfse_back #(
    parameter int ITEM_W = 77,
    parameter int LEN_W  = 7
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_ready,
    input  logic [ITEM_W-1:0] q_vec,
    input  logic [LEN_W-1:0]  q_len,
    input  logic              q_last,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        packed_byte,
    output logic              byte_is_final
);
    import xfse_pkg::*;

`include "xor_float_stream_encoder_top_defines.svh"

    localparam int BUF_W = ITEM_W + PEND_W;
    localparam int CNT_W = $clog2(BUF_W + 1);

    logic [BUF_W-1:0]  buf_reg;
    logic [BUF_W-1:0]  buf_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              last_reg;
    logic              last_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;
    logic              final_reg;
    logic              final_next;

    logic              have_byte;
    logic              out_load;
    logic              pop;

    // a full byte, or the flush of the chunk's last partial byte
    assign have_byte = (cnt_reg >= CNT_W'(BYTE_W)) || (last_reg && cnt_reg != '0);
    assign out_load  = have_byte && (!out_valid_reg || out_ready);
    assign pop       = q_valid && !have_byte;
    assign q_ready   = pop;

    always_comb
    begin
        buf_next       = buf_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        byte_next      = byte_reg;
        final_next     = final_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            byte_next      = buf_reg[BYTE_W-1:0];
            final_next     = last_reg && (cnt_reg <= CNT_W'(BYTE_W));
            buf_next       = buf_reg >> BYTE_W;
            cnt_next       = (cnt_reg >= CNT_W'(BYTE_W)) ? cnt_reg - CNT_W'(BYTE_W) : '0;
            last_next      = last_reg && (cnt_reg > CNT_W'(BYTE_W));
        end
        else if (pop)
        begin
            buf_next  = buf_reg | (BUF_W'(q_vec) << cnt_reg);
            cnt_next  = cnt_reg + CNT_W'(q_len);
            last_next = q_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg       <= '0;
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            buf_reg       <= buf_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        final_reg <= final_next;
    end

    assign out_valid     = out_valid_reg;
    assign packed_byte   = byte_reg;
    assign byte_is_final = final_reg;

    `XFSE_ASSERT(buf_clean_a, clk, rst_n, (buf_reg >> cnt_reg) == '0)
    `XFSE_ASSERT(cnt_bound_a, clk, rst_n, cnt_reg <= CNT_W'(BUF_W))
    `XFSE_ASSERT(last_pending_a, clk, rst_n, !last_reg || cnt_reg != '0)
    `XFSE_ASSERT(pop_partial_a, clk, rst_n, !pop || (cnt_reg < CNT_W'(BYTE_W) && !last_reg))
    `XFSE_ASSERT_NEXT(final_drains_a, clk, rst_n, out_load && final_next, cnt_reg == '0)

endmodule

// ----- hdl/xor_float_stream_encoder_top.sv -----
// top level of the xor float stream encoder
// Encodes a stream of float bit patterns with xor compression into an LSB-first byte
// stream. The front end takes one value per cycle while its queue has room; the packer
// merges each value's bit record into its pending bits, takes no new record while it
// holds a full byte or a chunk's last partial byte, and the one-byte output port sets
// the sustained rate. A value passes the front-end register, the queue, the packer's
// pending bits and its output byte register. wide_values (reset 1) selects VALUE_BITS-bit
// values with 6-bit fields, 0 selects 32-bit values with 5-bit fields; write it only
// while idle.
module xor_float_stream_encoder_top #(
    parameter int VALUE_BITS  = 64,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_wide_values,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [xfse_pkg::WORD_W-1:0] value_bits,
    input  logic                        chunk_end,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  packed_byte,
    output logic                        byte_is_final
);
    import xfse_pkg::*;

    localparam int ITEM_W = 1 + 2 * WIDE_FIELD + VALUE_BITS;
    localparam int LEN_W  = $clog2(ITEM_W + 1);
    localparam int Q_W    = ITEM_W + LEN_W + 1;

    logic              wide_values_reg;
    logic              wide_values_next;

    logic              f_valid;
    logic              f_ready;
    logic [ITEM_W-1:0] f_vec;
    logic [LEN_W-1:0]  f_len;
    logic              f_last;

    logic              b_valid;
    logic              b_ready;
    logic [Q_W-1:0]    b_data;

    assign cfg_ready        = 1'b1;
    assign wide_values_next = (cfg_valid && cfg_ready) ? cfg_wide_values : wide_values_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_values_reg <= 1'b1;
        end
        else
        begin
            wide_values_reg <= wide_values_next;
        end
    end

    xfse_front #(
        .VALUE_BITS (VALUE_BITS),
        .ITEM_W     (ITEM_W),
        .LEN_W      (LEN_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .wide_values (wide_values_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .value_bits  (value_bits),
        .chunk_end   (chunk_end),
        .q_valid     (f_valid),
        .q_ready     (f_ready),
        .q_vec       (f_vec),
        .q_len       (f_len),
        .q_last      (f_last)
    );

    xfse_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  ({f_last, f_len, f_vec}),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_data)
    );

    xfse_back #(
        .ITEM_W (ITEM_W),
        .LEN_W  (LEN_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (b_valid),
        .q_ready       (b_ready),
        .q_vec         (b_data[ITEM_W-1:0]),
        .q_len         (b_data[ITEM_W+LEN_W-1:ITEM_W]),
        .q_last        (b_data[Q_W-1]),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .packed_byte   (packed_byte),
        .byte_is_final (byte_is_final)
    );

endmodule
